FILE: hw/rtl/owms_pkg.sv
// ---------------------------------------------------------------------------
// owms_pkg
// shared types and constants for the one-wire master sequencer
// ---------------------------------------------------------------------------
`default_nettype none

package owms_pkg;

  localparam int TIME_W = 10;
  localparam int CFG_W  = 10;
  localparam int IDX_W  = 3;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [1:0] LN_LOW  = 2'd0;
  localparam logic [1:0] LN_HIGH = 2'd1;
  localparam logic [1:0] LN_FREE = 2'd2;

  localparam logic [IDX_W-1:0] REG_RESET_LOW  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRES_WAIT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RESET_TAIL = 3'd2;
  localparam logic [IDX_W-1:0] REG_SLOT_SHORT = 3'd3;
  localparam logic [IDX_W-1:0] REG_SLOT_LONG  = 3'd4;
  localparam logic [IDX_W-1:0] REG_READ_LEAD  = 3'd5;
  localparam logic [IDX_W-1:0] REG_READ_ZTAIL = 3'd6;

  localparam logic [CFG_W-1:0] RST_RESET_LOW  = 10'd700;
  localparam logic [CFG_W-1:0] RST_PRES_WAIT  = 10'd80;
  localparam logic [CFG_W-1:0] RST_RESET_TAIL = 10'd400;
  localparam logic [CFG_W-1:0] RST_SLOT_SHORT = 10'd10;
  localparam logic [CFG_W-1:0] RST_SLOT_LONG  = 10'd80;
  localparam logic [CFG_W-1:0] RST_READ_LEAD  = 10'd50;
  localparam logic [CFG_W-1:0] RST_READ_ZTAIL = 10'd100;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] line_state;
    logic       done_res;
    logic       result_bit;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  // classified word passed from front to back
  typedef struct packed {
    logic       tick;
    logic       cmd_reset;
    logic       cmd_write;
    logic       cmd_read;
    logic [7:0] data_byte;
    logic       line_level;
  } op_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_TAIL = 10'b00_0000_1000,
    PH_WR_LOW   = 10'b00_0001_0000,
    PH_WR_HIGH  = 10'b00_0010_0000,
    PH_RD_LEAD  = 10'b00_0100_0000,
    PH_RD_LOW   = 10'b00_1000_0000,
    PH_RD_WAIT  = 10'b01_0000_0000,
    PH_RD_TAIL  = 10'b10_0000_0000
  } phase_t;

endpackage

`default_nettype wire

FILE: hw/rtl/owms_front.sv
// ---------------------------------------------------------------------------
// owms_front
// accepts input words and decodes the mode into a classified word
// ---------------------------------------------------------------------------
`default_nettype none

module owms_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire owms_pkg::in_item_t in_item,
  output logic                   op_valid,
  input  wire logic              op_stall,
  output owms_pkg::op_t          op
);

  logic          valid_r;
  logic          valid_nxt;
  owms_pkg::op_t op_r;
  owms_pkg::op_t op_nxt;
  logic          take;

  assign in_stall = valid_r && op_stall;
  assign take     = in_valid && !in_stall;

  always_comb begin
    op_nxt            = op_r;
    valid_nxt         = valid_r && op_stall;
    if (take) begin
      valid_nxt            = 1'b1;
      op_nxt.tick          = (in_item.mode == owms_pkg::MODE_TICK);
      op_nxt.cmd_reset     = (in_item.mode == owms_pkg::MODE_RESET);
      op_nxt.cmd_write     = (in_item.mode == owms_pkg::MODE_WRITE);
      op_nxt.cmd_read      = (in_item.mode == owms_pkg::MODE_READ);
      op_nxt.data_byte     = in_item.data_byte;
      op_nxt.line_level    = in_item.line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    op_r <= op_nxt;
  end

  assign op_valid = valid_r;
  assign op       = op_r;

endmodule

`default_nettype wire

FILE: hw/rtl/owms_queue.sv
// ---------------------------------------------------------------------------
// owms_queue
// two-entry queue between the decode front and the sequencer back
// ---------------------------------------------------------------------------
`default_nettype none

module owms_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  input  wire owms_pkg::op_t     push_op,
  input  wire logic              pop,
  output owms_pkg::q_status_t    status,
  output owms_pkg::op_t          pop_op
);

  owms_pkg::op_t mem [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       do_pop;

  assign status.valid = (cnt_r != 2'd0);
  assign status.full  = (cnt_r == 2'd2);
  assign push         = push_valid && !status.full;
  assign do_pop       = pop && status.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

  assign pop_op = mem[rd_ptr_r];

endmodule

`default_nettype wire

FILE: hw/rtl/owms_back.sv
// ---------------------------------------------------------------------------
// owms_back
// slot timing sequencer, timing registers and result register
// ---------------------------------------------------------------------------
`default_nettype none

module owms_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire owms_pkg::q_status_t            q_status,
  input  wire owms_pkg::op_t                  q_op,
  output logic                                q_pop,
  input  wire logic                           cfg_valid,
  input  wire logic [owms_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [owms_pkg::CFG_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output owms_pkg::out_item_t                 out_item
);

  logic [owms_pkg::CFG_W-1:0] rst_low_r, pres_wait_r, rst_tail_r;
  logic [owms_pkg::CFG_W-1:0] slot_short_r, slot_long_r, read_lead_r, read_ztail_r;

  owms_pkg::phase_t            phase_r, phase_nxt;
  logic [owms_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [2:0]                  bits_r, bits_nxt;
  logic [7:0]                  shift_r, shift_nxt;
  logic                        sampled_r, sampled_nxt;
  logic [1:0]                  drive_r, drive_nxt;
  logic                        out_valid_r, out_valid_nxt;
  owms_pkg::out_item_t         out_r, out_nxt;
  logic                        done, result, rej;
  logic                        wr_bit;

  assign q_pop = q_status.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_low_r    <= owms_pkg::RST_RESET_LOW;
      pres_wait_r  <= owms_pkg::RST_PRES_WAIT;
      rst_tail_r   <= owms_pkg::RST_RESET_TAIL;
      slot_short_r <= owms_pkg::RST_SLOT_SHORT;
      slot_long_r  <= owms_pkg::RST_SLOT_LONG;
      read_lead_r  <= owms_pkg::RST_READ_LEAD;
      read_ztail_r <= owms_pkg::RST_READ_ZTAIL;
    end else if (cfg_valid) begin
      case (cfg_index)
        owms_pkg::REG_RESET_LOW:  rst_low_r    <= cfg_data;
        owms_pkg::REG_PRES_WAIT:  pres_wait_r  <= cfg_data;
        owms_pkg::REG_RESET_TAIL: rst_tail_r   <= cfg_data;
        owms_pkg::REG_SLOT_SHORT: slot_short_r <= cfg_data;
        owms_pkg::REG_SLOT_LONG:  slot_long_r  <= cfg_data;
        owms_pkg::REG_READ_LEAD:  read_lead_r  <= cfg_data;
        owms_pkg::REG_READ_ZTAIL: read_ztail_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    time_nxt      = time_r;
    bits_nxt      = bits_r;
    shift_nxt     = shift_r;
    sampled_nxt   = sampled_r;
    drive_nxt     = drive_r;
    done          = 1'b0;
    result        = 1'b0;
    rej           = 1'b0;
    wr_bit        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (q_pop) begin
      if (!q_op.tick) begin
        if (phase_r != owms_pkg::PH_IDLE) begin
          rej = 1'b1;
        end else if (q_op.cmd_reset) begin
          drive_nxt = owms_pkg::LN_LOW;
          time_nxt  = owms_pkg::TIME_W'(rst_low_r);
          phase_nxt = owms_pkg::PH_RST_LOW;
        end else if (q_op.cmd_write) begin
          shift_nxt = q_op.data_byte;
          bits_nxt  = 3'd7;
          wr_bit    = 1'b1;
        end else begin
          drive_nxt = owms_pkg::LN_HIGH;
          time_nxt  = owms_pkg::TIME_W'(read_lead_r);
          phase_nxt = owms_pkg::PH_RD_LEAD;
        end
      end else if (phase_r != owms_pkg::PH_IDLE) begin
        if (time_r > owms_pkg::TIME_W'(1)) begin
          time_nxt = time_r - owms_pkg::TIME_W'(1);
        end else begin
          time_nxt = '0;
          case (phase_r)
            owms_pkg::PH_RST_LOW: begin
              drive_nxt = owms_pkg::LN_FREE;
              time_nxt  = owms_pkg::TIME_W'(pres_wait_r);
              phase_nxt = owms_pkg::PH_RST_WAIT;
            end
            owms_pkg::PH_RST_WAIT: begin
              sampled_nxt = !q_op.line_level;
              time_nxt    = owms_pkg::TIME_W'(rst_tail_r);
              phase_nxt   = owms_pkg::PH_RST_TAIL;
            end
            owms_pkg::PH_RST_TAIL: begin
              drive_nxt = owms_pkg::LN_HIGH;
              done      = 1'b1;
              result    = sampled_r;
              phase_nxt = owms_pkg::PH_IDLE;
            end
            owms_pkg::PH_WR_LOW: begin
              drive_nxt = owms_pkg::LN_HIGH;
              time_nxt  = owms_pkg::TIME_W'(shift_r[0] ? slot_long_r : slot_short_r);
              phase_nxt = owms_pkg::PH_WR_HIGH;
            end
            owms_pkg::PH_WR_HIGH: begin
              if (bits_r == 3'd0) begin
                done      = 1'b1;
                phase_nxt = owms_pkg::PH_IDLE;
              end else begin
                bits_nxt  = bits_r - 3'd1;
                shift_nxt = {1'b0, shift_r[7:1]};
                wr_bit    = 1'b1;
              end
            end
            owms_pkg::PH_RD_LEAD: begin
              drive_nxt = owms_pkg::LN_LOW;
              time_nxt  = owms_pkg::TIME_W'(slot_short_r);
              phase_nxt = owms_pkg::PH_RD_LOW;
            end
            owms_pkg::PH_RD_LOW: begin
              drive_nxt = owms_pkg::LN_FREE;
              time_nxt  = owms_pkg::TIME_W'(slot_short_r);
              phase_nxt = owms_pkg::PH_RD_WAIT;
            end
            owms_pkg::PH_RD_WAIT: begin
              sampled_nxt = q_op.line_level;
              if (q_op.line_level) begin
                drive_nxt = owms_pkg::LN_HIGH;
                done      = 1'b1;
                result    = 1'b1;
                phase_nxt = owms_pkg::PH_IDLE;
              end else begin
                time_nxt  = owms_pkg::TIME_W'(read_ztail_r);
                phase_nxt = owms_pkg::PH_RD_TAIL;
              end
            end
            owms_pkg::PH_RD_TAIL: begin
              drive_nxt = owms_pkg::LN_HIGH;
              done      = 1'b1;
              phase_nxt = owms_pkg::PH_IDLE;
            end
            default: phase_nxt = owms_pkg::PH_IDLE;
          endcase
        end
      end
      // first low part of a write bit, length set by the bit value
      if (wr_bit) begin
        drive_nxt = owms_pkg::LN_LOW;
        time_nxt  = owms_pkg::TIME_W'(shift_nxt[0] ? slot_short_r : slot_long_r);
        phase_nxt = owms_pkg::PH_WR_LOW;
      end
      out_valid_nxt      = 1'b1;
      out_nxt.line_state = drive_nxt;
      out_nxt.done_res   = done;
      out_nxt.result_bit = result;
      out_nxt.busy_res   = (phase_nxt != owms_pkg::PH_IDLE);
      out_nxt.rejected   = rej;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= owms_pkg::PH_IDLE;
      time_r      <= '0;
      bits_r      <= 3'd0;
      shift_r     <= 8'd0;
      sampled_r   <= 1'b0;
      drive_r     <= owms_pkg::LN_HIGH;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      time_r      <= time_nxt;
      bits_r      <= bits_nxt;
      shift_r     <= shift_nxt;
      sampled_r   <= sampled_nxt;
      drive_r     <= drive_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rejected) |-> (out_r.busy_res && !out_r.done_res))
    else $error("rejected word without a running command");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |->
      (!out_r.busy_res && out_r.line_state == owms_pkg::LN_HIGH))
    else $error("completion with bus not idle high");

  a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.result_bit) |-> out_r.done_res)
    else $error("result bit outside a completion");

  a_wr_low: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == owms_pkg::PH_WR_LOW || phase_r == owms_pkg::PH_RD_LOW ||
     phase_r == owms_pkg::PH_RST_LOW) |-> (drive_r == owms_pkg::LN_LOW))
    else $error("low phase without line driven low");

endmodule

`default_nettype wire

FILE: hw/rtl/one_wire_master_sequencer_unit.sv
// ---------------------------------------------------------------------------
// one_wire_master_sequencer_unit
// one-wire bus master: reset with presence detect, byte write, bit read
// ---------------------------------------------------------------------------
// Takes one word per clock while the queue is not full, and returns exactly
// one result word for every word taken. A word is either a command or a
// tick carrying the sampled bus level; the result gives the line drive state
// after it, and done with the result bit on the tick that ends a command. A
// word passes through the decode register, the two-entry queue and the
// sequencer that writes the result register; the queue lets a stalled result
// side not hold the input side at once. Timing registers are written
// through the cfg port, which is always ready and should only be used while
// no command runs.
`default_nettype none

module one_wire_master_sequencer_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire owms_pkg::in_item_t         in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output owms_pkg::out_item_t             out_item,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [owms_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [owms_pkg::CFG_W-1:0] cfg_data
);

  logic                 op_valid;
  owms_pkg::op_t        op;
  owms_pkg::q_status_t  q_status;
  owms_pkg::op_t        q_op;
  logic                 q_pop;

  assign cfg_ready = 1'b1;

  owms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .op_valid (op_valid),
    .op_stall (q_status.full),
    .op       (op)
  );

  owms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (op_valid),
    .push_op    (op),
    .pop        (q_pop),
    .status     (q_status),
    .pop_op     (q_op)
  );

  owms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the one-wire master sequencer unit
// ---------------------------------------------------------------------------
// A queue of words feeds a clocked driver and a clocked monitor checks every
// result word against a cycle-free model of the sequencer that steps once per
// accepted word. The run does a read on the reset timing, then runs a short
// directed list of commands, then random command runs with ticks under three
// idling regimes and several timing settings. Timing is only reprogrammed
// while the sequencer is idle and no result is outstanding.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  owms_pkg::in_item_t            in_item   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  owms_pkg::out_item_t           out_item;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [owms_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [owms_pkg::CFG_W-1:0]    cfg_data  = '0;

  owms_pkg::in_item_t            words_to_send[$];
  owms_pkg::out_item_t           bus_results_due[$];
  int                            snd_idle_pct = 9;
  int                            rcv_idle_pct = 83;
  int                            fails        = 0;
  int                            cycles       = 0;
  logic [owms_pkg::CFG_W-1:0]    timing_plan [0:7];

  // model state
  logic [owms_pkg::CFG_W-1:0]    timing [0:6];
  owms_pkg::phase_t              bus_phase;
  logic [owms_pkg::TIME_W-1:0]   ticks_left;
  logic [2:0]                    bits_to_go;
  logic [7:0]                    tx_bits;
  logic                          line_sample;
  logic [1:0]                    line_drive;

  one_wire_master_sequencer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void start_slot();
    line_drive = owms_pkg::LN_LOW;
    ticks_left = tx_bits[0] ? timing[owms_pkg::REG_SLOT_SHORT] :
                              timing[owms_pkg::REG_SLOT_LONG];
    bus_phase  = owms_pkg::PH_WR_LOW;
  endfunction

  function automatic owms_pkg::out_item_t advance_bus(owms_pkg::in_item_t w);
    owms_pkg::out_item_t r;
    r = '0;
    if (w.mode != owms_pkg::MODE_TICK) begin
      if (bus_phase != owms_pkg::PH_IDLE) begin
        r.rejected = 1'b1;
      end else if (w.mode == owms_pkg::MODE_RESET) begin
        line_drive = owms_pkg::LN_LOW;
        ticks_left = timing[owms_pkg::REG_RESET_LOW];
        bus_phase  = owms_pkg::PH_RST_LOW;
      end else if (w.mode == owms_pkg::MODE_WRITE) begin
        tx_bits    = w.data_byte;
        bits_to_go = 3'd7;
        start_slot();
      end else begin
        line_drive = owms_pkg::LN_HIGH;
        ticks_left = timing[owms_pkg::REG_READ_LEAD];
        bus_phase  = owms_pkg::PH_RD_LEAD;
      end
    end else if (bus_phase != owms_pkg::PH_IDLE) begin
      if (ticks_left > 1) begin
        ticks_left = ticks_left - 1'b1;
      end else begin
        ticks_left = '0;
        case (bus_phase)
          owms_pkg::PH_RST_LOW: begin
            line_drive = owms_pkg::LN_FREE;
            ticks_left = timing[owms_pkg::REG_PRES_WAIT];
            bus_phase  = owms_pkg::PH_RST_WAIT;
          end
          owms_pkg::PH_RST_WAIT: begin
            line_sample = ~w.line_level;
            ticks_left  = timing[owms_pkg::REG_RESET_TAIL];
            bus_phase   = owms_pkg::PH_RST_TAIL;
          end
          owms_pkg::PH_RST_TAIL: begin
            line_drive   = owms_pkg::LN_HIGH;
            r.done_res   = 1'b1;
            r.result_bit = line_sample;
            bus_phase    = owms_pkg::PH_IDLE;
          end
          owms_pkg::PH_WR_LOW: begin
            line_drive = owms_pkg::LN_HIGH;
            ticks_left = tx_bits[0] ? timing[owms_pkg::REG_SLOT_LONG] :
                                      timing[owms_pkg::REG_SLOT_SHORT];
            bus_phase  = owms_pkg::PH_WR_HIGH;
          end
          owms_pkg::PH_WR_HIGH: begin
            if (bits_to_go == 3'd0) begin
              r.done_res = 1'b1;
              bus_phase  = owms_pkg::PH_IDLE;
            end else begin
              bits_to_go = bits_to_go - 1'b1;
              tx_bits    = tx_bits >> 1;
              start_slot();
            end
          end
          owms_pkg::PH_RD_LEAD: begin
            line_drive = owms_pkg::LN_LOW;
            ticks_left = timing[owms_pkg::REG_SLOT_SHORT];
            bus_phase  = owms_pkg::PH_RD_LOW;
          end
          owms_pkg::PH_RD_LOW: begin
            line_drive = owms_pkg::LN_FREE;
            ticks_left = timing[owms_pkg::REG_SLOT_SHORT];
            bus_phase  = owms_pkg::PH_RD_WAIT;
          end
          owms_pkg::PH_RD_WAIT: begin
            line_sample = w.line_level;
            if (w.line_level) begin
              line_drive   = owms_pkg::LN_HIGH;
              r.done_res   = 1'b1;
              r.result_bit = 1'b1;
              bus_phase    = owms_pkg::PH_IDLE;
            end else begin
              ticks_left = timing[owms_pkg::REG_READ_ZTAIL];
              bus_phase  = owms_pkg::PH_RD_TAIL;
            end
          end
          owms_pkg::PH_RD_TAIL: begin
            line_drive = owms_pkg::LN_HIGH;
            r.done_res = 1'b1;
            bus_phase  = owms_pkg::PH_IDLE;
          end
          default: begin
            bus_phase = owms_pkg::PH_IDLE;
          end
        endcase
      end
    end
    r.line_state = line_drive;
    r.busy_res   = (bus_phase != owms_pkg::PH_IDLE);
    return r;
  endfunction

  // a register of zero still lasts one tick
  function automatic int span(logic [owms_pkg::CFG_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  // longest run of ticks a command can take
  function automatic int command_span(logic [1:0] m);
    case (m)
      owms_pkg::MODE_RESET: begin
        return span(timing[owms_pkg::REG_RESET_LOW]) +
               span(timing[owms_pkg::REG_PRES_WAIT]) +
               span(timing[owms_pkg::REG_RESET_TAIL]);
      end
      owms_pkg::MODE_WRITE: begin
        return 8 * (span(timing[owms_pkg::REG_SLOT_SHORT]) +
                    span(timing[owms_pkg::REG_SLOT_LONG]));
      end
      default: begin
        return span(timing[owms_pkg::REG_READ_LEAD]) +
               2 * span(timing[owms_pkg::REG_SLOT_SHORT]) +
               span(timing[owms_pkg::REG_READ_ZTAIL]);
      end
    endcase
  endfunction

  function automatic owms_pkg::in_item_t cmd_word(logic [1:0] m, logic [7:0] d);
    owms_pkg::in_item_t w;
    w.mode       = m;
    w.data_byte  = d;
    w.line_level = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic logic [owms_pkg::CFG_W-1:0] pick_timing();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end
    if (r < 16) begin
      return owms_pkg::CFG_W'($urandom_range(1, 4));
    end
    return owms_pkg::CFG_W'($urandom_range(5, 24));
  endfunction

  // negative level means random
  task automatic push_ticks(int n, int lvl);
    owms_pkg::in_item_t w;
    for (int k = 0; k < n; k++) begin
      w.mode       = owms_pkg::MODE_TICK;
      w.data_byte  = 8'($urandom);
      w.line_level = (lvl < 0) ? 1'($urandom_range(0, 1)) : 1'(lvl);
      words_to_send.push_back(w);
    end
  endtask

  task automatic wait_drained();
    while (words_to_send.size() != 0 || in_valid || bus_results_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic settle();
    wait_drained();
    while (bus_phase != owms_pkg::PH_IDLE) begin
      push_ticks(16, -1);
      wait_drained();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic program_timing();
    cfg_valid <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= owms_pkg::IDX_W'(i);
      cfg_data  <= timing_plan[i];
      do @(posedge clk); while (!cfg_ready);
      if (i <= int'(owms_pkg::REG_READ_ZTAIL)) begin
        timing[i] = timing_plan[i];
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int quota);
    int       pushed;
    int       n;
    int       d;
    bit       paused;
    logic [1:0] m;
    pushed = 0;
    paused = 1'b0;
    while (pushed < quota) begin
      m = 2'($urandom_range(1, 3));
      words_to_send.push_back(cmd_word(m, 8'($urandom)));
      d = command_span(m);
      n = ($urandom_range(0, 9) < 8) ? d + $urandom_range(0, 3) : $urandom_range(0, d);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 29) == 0) begin
          words_to_send.push_back(cmd_word(2'($urandom_range(1, 3)), 8'($urandom)));
        end else begin
          push_ticks(1, -1);
        end
      end
      pushed += n + 1;
      if (!paused && pushed >= quota / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bus_results_due.push_back(advance_bus(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (words_to_send.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= words_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin : watch_results
    owms_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_results_due.size() == 0) begin
        if (fails < 10) begin
          $display("unexpected word: line %0d done %0b bit %0b busy %0b rej %0b",
                   out_item.line_state, out_item.done_res, out_item.result_bit,
                   out_item.busy_res, out_item.rejected);
        end
        fails++;
      end else begin
        want = bus_results_due.pop_front();
        if (out_item.line_state !== want.line_state || out_item.done_res !== want.done_res ||
            out_item.result_bit !== want.result_bit || out_item.busy_res !== want.busy_res ||
            out_item.rejected !== want.rejected) begin
          if (fails < 10) begin
            $display("mismatch: expected line %0d done %0b bit %0b busy %0b rej %0b",
                     want.line_state, want.done_res, want.result_bit, want.busy_res,
                     want.rejected);
            $display("          got      line %0d done %0b bit %0b busy %0b rej %0b",
                     out_item.line_state, out_item.done_res, out_item.result_bit,
                     out_item.busy_res, out_item.rejected);
          end
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    timing[owms_pkg::REG_RESET_LOW]  = owms_pkg::RST_RESET_LOW;
    timing[owms_pkg::REG_PRES_WAIT]  = owms_pkg::RST_PRES_WAIT;
    timing[owms_pkg::REG_RESET_TAIL] = owms_pkg::RST_RESET_TAIL;
    timing[owms_pkg::REG_SLOT_SHORT] = owms_pkg::RST_SLOT_SHORT;
    timing[owms_pkg::REG_SLOT_LONG]  = owms_pkg::RST_SLOT_LONG;
    timing[owms_pkg::REG_READ_LEAD]  = owms_pkg::RST_READ_LEAD;
    timing[owms_pkg::REG_READ_ZTAIL] = owms_pkg::RST_READ_ZTAIL;
    bus_phase   = owms_pkg::PH_IDLE;
    ticks_left  = '0;
    bits_to_go  = '0;
    tx_bits     = '0;
    line_sample = 1'b0;
    line_drive  = owms_pkg::LN_HIGH;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // one read on the reset timing
    push_ticks(2, -1);
    words_to_send.push_back(cmd_word(owms_pkg::MODE_READ, 8'h00));
    push_ticks(70, 1);
    settle();

    // short timing, zero where it should act as one, unused index written
    timing_plan = '{10'd1, 10'd0, 10'd2, 10'd1, 10'd1, 10'd1, 10'd0, 10'd1023};
    program_timing();
    push_ticks(1, 0);
    push_ticks(1, 1);
    words_to_send.push_back(cmd_word(owms_pkg::MODE_RESET, 8'h00));
    words_to_send.push_back(cmd_word(owms_pkg::MODE_WRITE, 8'h00));
    push_ticks(4, 0);
    words_to_send.push_back(cmd_word(owms_pkg::MODE_WRITE, 8'hFF));
    push_ticks(16, 1);
    words_to_send.push_back(cmd_word(owms_pkg::MODE_READ, 8'h00));
    words_to_send.push_back(cmd_word(owms_pkg::MODE_RESET, 8'hFF));
    push_ticks(3, 1);
    words_to_send.push_back(cmd_word(owms_pkg::MODE_READ, 8'h00));
    push_ticks(4, 0);
    settle();

    for (int r = 0; r < 3; r++) begin
      snd_idle_pct = (r == 0) ? 9 : (r == 1) ? 83 : 0;
      rcv_idle_pct = (r == 0) ? 83 : (r == 1) ? 9 : 0;
      for (int s = 0; s < 2; s++) begin
        foreach (timing_plan[i]) timing_plan[i] = pick_timing();
        timing_plan[7] = owms_pkg::CFG_W'($urandom);
        program_timing();
        run_random(80);
        settle();
      end
    end

    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
